@@ hdl/kwch_pkg.sv @@
`timescale 1ns / 1ps
package kwch_pkg;
  localparam int HistBins = 4096;
  localparam int IdxW = 12;
  localparam int SumW = 40;
  localparam int TotW = 48;
  localparam int NormW = 17;
  localparam int Lanes = 3;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ACC   = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CFG_BINS_FIRST  = 3'd0,
    CFG_BINS_SECOND = 3'd1,
    CFG_BINS_THIRD  = 3'd2,
    CFG_RANGE_MIN   = 3'd3,
    CFG_RANGE_MAX   = 3'd4,
    CFG_CHANNELS    = 3'd5
  } cfg_idx_t;

  // per-lane result: bin and out-of-range flag
  typedef struct packed {
    logic [3:0] bin;
    logic       flag;
  } lane_res_t;

  function automatic logic [4:0] clip_bins(input logic [4:0] n);
    logic [4:0] r;
    r = n;
    if (n < 5'd2) r = 5'd2;
    if (n > 5'd16) r = 5'd16;
    return r;
  endfunction
endpackage

@@ hdl/kernel_weighted_color_histogram_top.sv @@
`timescale 1ns / 1ps
// Kernel-weighted color histogram (mean-shift tracking).
// Input channel: in_valid/in_stall with mode, chan_*, weight, read_bin.
// Output channel: out_valid/out_stall with bin_index, raw_sum, normalized, clamped.
// Config: cfg_we/cfg_index/cfg_data, to be written by the user only while idle; the block does not enforce it.
// Mode 1 (accumulate): three lanes find the channel bins in 12 divider steps, a
// merge forms the mixed-radix index, the bin is read, updated and written, and a
// 56-step serial divider produces the share, which is then placed in the output
// register; the next word is taken once that result has been registered.
// Mode 2 (read): one memory read, with no write back, then the same divider.
// Mode 0 (clear): the zero result shows in the cycle after acceptance, then the
// 4096-entry store is walked one entry a cycle; the next word waits for the walk.
// One word is processed at a time. A finished result waits for a free output
// register; a clear word waits until the output register is empty.
// Mode 3 words are accepted and dropped.
// After reset the block sweeps the 4096-entry store to zero and holds
// in_stall high. A stalled result holds in the output register unchanged.
module kernel_weighted_color_histogram_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  chan_first,
  input  logic [7:0]  chan_second,
  input  logic [7:0]  chan_third,
  input  logic [15:0] weight,
  input  logic [11:0] read_bin,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] bin_index,
  output logic [39:0] raw_sum,
  output logic [16:0] normalized,
  output logic        clamped,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import kwch_pkg::*;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_LANE = 7'b0000100,
    S_RD   = 7'b0001000,
    S_UPD  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;
  logic [4:0] bins_first, bins_second, bins_third;
  logic [7:0] range_min, range_max;
  logic [1:0] channels_used;

  logic [SumW-1:0] mem [HistBins];
  logic [SumW-1:0] rdata;
  logic [IdxW-1:0] addr;
  logic [IdxW:0]   clr_cnt;
  logic [TotW-1:0] total;
  logic            flag;
  logic [SumW-1:0] sum;
  logic            is_read;
  logic [15:0]     wgt;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bins_first <= 5'd16; bins_second <= 5'd16; bins_third <= 5'd16;
      range_min <= 8'd0; range_max <= 8'd255; channels_used <= 2'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        8'(CFG_BINS_FIRST):  bins_first <= cfg_data[4:0];
        8'(CFG_BINS_SECOND): bins_second <= cfg_data[4:0];
        8'(CFG_BINS_THIRD):  bins_third <= cfg_data[4:0];
        8'(CFG_RANGE_MIN):   range_min <= cfg_data;
        8'(CFG_RANGE_MAX):   range_max <= cfg_data;
        8'(CFG_CHANNELS):    channels_used <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [4:0] nb1, nb2, nb3;
  assign nb1 = clip_bins(bins_first);
  assign nb2 = clip_bins(bins_second);
  assign nb3 = clip_bins(bins_third);

  // lanes
  logic lane_start;
  logic [2:0] lane_done;
  lane_res_t r1, r2, r3;
  assign lane_start = (state == S_IDLE) && in_valid && (mode == MODE_ACC);
  kwch_lane u_l0 (.clk, .rst, .start(lane_start), .val(chan_first), .nbins(nb1),
    .rmin(range_min), .rmax(range_max), .done(lane_done[0]), .res(r1));
  kwch_lane u_l1 (.clk, .rst, .start(lane_start), .val(chan_second), .nbins(nb2),
    .rmin(range_min), .rmax(range_max), .done(lane_done[1]), .res(r2));
  kwch_lane u_l2 (.clk, .rst, .start(lane_start), .val(chan_third), .nbins(nb3),
    .rmin(range_min), .rmax(range_max), .done(lane_done[2]), .res(r3));

  // merge lanes into a mixed-radix index
  logic [1:0]  nch;
  logic [13:0] midx;
  logic        mflag;
  always_comb begin
    nch = (channels_used == 2'd0) ? 2'd1 : channels_used;
    midx = {10'd0, r1.bin};
    mflag = r1.flag;
    if (nch >= 2'd2) begin
      midx = midx + 14'(r2.bin * nb1);
      mflag = mflag | r2.flag;
    end
    if (nch == 2'd3) begin
      midx = midx + 14'(r3.bin * 9'(nb1 * nb2));
      mflag = mflag | r3.flag;
    end
    if (midx >= 14'(HistBins)) begin
      midx = 14'(HistBins - 1);
      mflag = 1'b1;
    end
  end

  // new bin sum and total, saturated; a read passes them through unchanged
  logic [SumW:0]   s_ext;
  logic [TotW:0]   t_ext;
  logic [SumW-1:0] sum_next;
  logic [TotW-1:0] total_next;
  assign s_ext = {1'b0, rdata} + (SumW+1)'(wgt);
  assign t_ext = {1'b0, total} + (TotW+1)'(wgt);
  always_comb begin
    if (is_read) begin
      sum_next = rdata;
      total_next = total;
    end else begin
      sum_next = s_ext[SumW] ? {SumW{1'b1}} : s_ext[SumW-1:0];
      total_next = t_ext[TotW] ? {TotW{1'b1}} : t_ext[TotW-1:0];
    end
  end

  // divider
  logic div_start, div_done;
  logic [NormW-1:0] quot;
  kwch_divq u_div (.clk, .rst, .start(div_start), .sum(sum_next), .total(total_next),
    .done(div_done), .quot(quot));

  // memory
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [SumW-1:0] wdata;
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[addr];
  end

  always_comb begin
    we = 1'b0; waddr = addr; wdata = '0;
    if (state == S_CLR) begin
      we = 1'b1; waddr = clr_cnt[IdxW-1:0];
    end else if (state == S_UPD && !is_read) begin
      we = 1'b1;
      wdata = sum_next;
    end
  end

  assign in_stall = (state != S_IDLE) || (out_valid && mode == MODE_CLEAR);
  assign div_start = (state == S_UPD);

  // output valid: set on a new result, drop when taken
  logic out_set;
  assign out_set = (state == S_IDLE && in_valid && !in_stall && mode == MODE_CLEAR) ||
                   (state == S_OUT && (!out_valid || !out_stall));
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_set) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  // sequencer (weight is captured with the accepted word)
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr_cnt <= '0; total <= '0;
    end else begin
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 13'd1;
          if (clr_cnt == (IdxW+1)'(HistBins - 1)) begin
            state <= S_IDLE;
            total <= '0;
          end
        end
        S_IDLE: if (in_valid && !in_stall) begin
          case (mode)
            MODE_CLEAR: begin
              clr_cnt <= '0; state <= S_CLR;
              bin_index <= '0; raw_sum <= '0; normalized <= '0; clamped <= 1'b0;
            end
            MODE_ACC:  begin is_read <= 1'b0; wgt <= weight; state <= S_LANE; end
            MODE_READ: begin
              is_read <= 1'b1; addr <= read_bin; state <= S_RD; flag <= 1'b0;
            end
            default: ;
          endcase
        end
        S_LANE: if (&lane_done) begin
          addr <= midx[IdxW-1:0]; flag <= mflag; state <= S_RD;
        end
        S_RD: state <= S_UPD;
        S_UPD: begin
          sum <= sum_next;
          if (!is_read) begin
            total <= total_next;
            flag <= flag | s_ext[SumW] | t_ext[TotW];
          end
          state <= S_DIV;
        end
        S_DIV: if (div_done) state <= S_OUT;
        S_OUT: if (!out_valid || !out_stall) begin
          bin_index <= addr; raw_sum <= sum; normalized <= quot; clamped <= flag;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/kwch_lane.sv @@
`timescale 1ns / 1ps
// One channel: clamp, scale by (bins-1), divide by span (iterative, 12 steps).
module kwch_lane (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [7:0]                 val,
  input  logic [4:0]                 nbins,
  input  logic [7:0]                 rmin,
  input  logic [7:0]                 rmax,
  output logic                       done,
  output kwch_pkg::lane_res_t        res
);
  import kwch_pkg::*;
  logic [11:0] quo;
  logic [8:0]  rem;
  logic [7:0]  span;
  logic [3:0]  cnt;
  logic        busy;
  logic        flag;
  logic [7:0]  v;
  logic [9:0]  trial;
  logic [11:0] prod;

  always_comb begin
    v = val;
    if (val < rmin) v = rmin;
    if (val > rmax) v = rmax;
    prod = 12'((v - rmin) * (nbins - 5'd1));
    trial = {rem, quo[11]} - {2'b0, span};
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        span <= rmax - rmin;
        flag <= (rmax <= rmin) || (val < rmin) || (val > rmax);
        quo  <= (rmax <= rmin) ? 12'd0 : prod;
        rem  <= 9'd0;
        cnt  <= 4'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!trial[9]) begin
          rem <= trial[8:0];
          quo <= {quo[10:0], 1'b1};
        end else begin
          rem <= {rem[7:0], quo[11]};
          quo <= {quo[10:0], 1'b0};
        end
        cnt <= cnt + 4'd1;
        if (cnt == 4'd11) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.bin  = (span == 8'd0) ? 4'd0 : quo[3:0];
  assign res.flag = flag;
endmodule

@@ hdl/kwch_divq.sv @@
`timescale 1ns / 1ps
// floor(sum*65536/total) saturated to 65536; one bit a cycle, 56 quotient bits.
module kwch_divq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [kwch_pkg::SumW-1:0]     sum,
  input  logic [kwch_pkg::TotW-1:0]     total,
  output logic                          done,
  output logic [kwch_pkg::NormW-1:0]    quot
);
  import kwch_pkg::*;
  logic [SumW+15:0] num;
  logic [TotW:0]    rem;
  logic [TotW-1:0]  den;
  logic [SumW+15:0] qf;
  logic [5:0]       cnt;
  logic             busy;
  logic             zero;
  logic [TotW+1:0]  trial;

  assign trial = {rem, num[SumW+15]} - {2'b0, den};

  // restoring division over the whole shifted numerator
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num  <= {sum, 16'd0};
        den  <= total;
        zero <= (total == '0);
        rem  <= '0;
        qf   <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        num <= {num[SumW+14:0], 1'b0};
        if (!trial[TotW+1]) rem <= trial[TotW:0];
        else rem <= {rem[TotW-1:0], num[SumW+15]};
        qf  <= {qf[SumW+14:0], ~trial[TotW+1]};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(SumW + 15)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // saturate at one; zero total gives zero
  always_comb begin
    quot = '0;
    if (!zero) begin
      if (qf > (SumW+16)'(65536)) quot = 17'd65536;
      else quot = qf[16:0];
    end
  end
endmodule

@@ hdl/kwch_check.sv @@
`timescale 1ns / 1ps
module kwch_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [39:0] raw_sum,
  input logic [16:0] normalized,
  input logic        clamped
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(raw_sum))
    else $error("stalled word changed");
  a_norm: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normalized <= 17'd65536)
    else $error("share above one");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && raw_sum == 40'd0 |-> normalized == 17'd0)
    else $error("share of empty bin nonzero");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result after reset");
endmodule

bind kernel_weighted_color_histogram_top kwch_check u_chk (.clk, .rst, .in_valid,
  .in_stall, .out_valid, .out_stall, .raw_sum, .normalized, .clamped);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import kwch_pkg::*;

  typedef struct {
    mode_t       op;
    logic [7:0]  c1, c2, c3;
    logic [15:0] wgt;
    logic [11:0] rbin;
  } pixel_word_t;

  typedef struct {
    logic [11:0] idx;
    logic [39:0] sum;
    logic [16:0] share;
    logic        clip;
  } bin_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = 2'd0;
  logic [7:0]  chan_first = 8'd0, chan_second = 8'd0, chan_third = 8'd0;
  logic [15:0] weight = 16'd0;
  logic [11:0] read_bin = 12'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] bin_index;
  logic [39:0] raw_sum;
  logic [16:0] normalized;
  logic        clamped;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_index = 8'd0;
  logic [7:0]  cfg_data = 8'd0;

  kernel_weighted_color_histogram_top u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // histogram shadow
  logic [39:0] hist_sums [HistBins];
  logic [47:0] weight_sum;
  logic [4:0]  nbins [3];
  logic [7:0]  lo_val, hi_val;
  logic [1:0]  lanes_on;

  pixel_word_t pixel_q[$];
  bin_result_t bin_q[$];
  int errors = 0;
  bit in_took = 0, out_took = 0;
  bit no_idle = 0;
  int send_gap = 0, stall_cnt = 0;

  function automatic logic [4:0] limit_bins(logic [4:0] n);
    if (n < 5'd2) return 5'd2;
    if (n > 5'd16) return 5'd16;
    return n;
  endfunction

  function automatic logic [16:0] share_of(logic [39:0] s);
    logic [63:0] q;
    if (weight_sum == 48'd0) return 17'd0;
    q = ({24'd0, s} << 16) / {16'd0, weight_sum};
    if (q > 64'd65536) q = 64'd65536;
    return q[16:0];
  endfunction

  // advance the shadow by one word; returns 1 when a result is due
  function automatic bit predict_bin(pixel_word_t w, output bin_result_t r);
    logic [7:0]  v [3];
    logic [31:0] idx, radix, span, b, val;
    logic [40:0] s;
    logic [48:0] t;
    int nch;
    bit flag;
    r = '{default: '0};
    flag = 0;
    case (w.op)
      MODE_CLEAR: begin
        for (int i = 0; i < HistBins; i++) hist_sums[i] = '0;
        weight_sum = '0;
        return 1;
      end
      MODE_ACC: begin
        v[0] = w.c1; v[1] = w.c2; v[2] = w.c3;
        nch = (lanes_on == 2'd0) ? 1 : int'(lanes_on);
        if (nch > Lanes) nch = Lanes;
        idx = 0; radix = 1;
        for (int k = 0; k < nch; k++) begin
          if (hi_val <= lo_val) begin
            flag = 1;
            b = 0;
          end else begin
            val = v[k];
            if (val < lo_val) begin val = lo_val; flag = 1; end
            if (val > hi_val) begin val = hi_val; flag = 1; end
            span = hi_val - lo_val;
            b = ((val - lo_val) * (limit_bins(nbins[k]) - 1)) / span;
          end
          idx += b * radix;
          radix *= limit_bins(nbins[k]);
        end
        if (idx >= HistBins) begin idx = HistBins - 1; flag = 1; end
        s = {1'b0, hist_sums[idx[11:0]]} + w.wgt;
        if (s[40]) begin s = {1'b0, {40{1'b1}}}; flag = 1; end
        hist_sums[idx[11:0]] = s[39:0];
        t = {1'b0, weight_sum} + w.wgt;
        if (t[48]) begin t = {1'b0, {48{1'b1}}}; flag = 1; end
        weight_sum = t[47:0];
        r.idx = idx[11:0];
        r.sum = s[39:0];
        r.share = share_of(s[39:0]);
        r.clip = flag;
        return 1;
      end
      MODE_READ: begin
        r.idx = w.rbin;
        r.sum = hist_sums[w.rbin];
        r.share = share_of(hist_sums[w.rbin]);
        r.clip = 1'b0;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // check results, then predict accepted words
  always @(posedge clk) begin
    bin_result_t e, r;
    if (!rst && out_valid && !out_stall) begin
      if (bin_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = bin_q.pop_front();
        if (bin_index !== e.idx) begin
          $error("bin_index exp %0d got %0d", e.idx, bin_index); errors++;
        end
        if (raw_sum !== e.sum) begin
          $error("raw_sum exp %0d got %0d", e.sum, raw_sum); errors++;
        end
        if (normalized !== e.share) begin
          $error("normalized exp %0d got %0d", e.share, normalized); errors++;
        end
        if (clamped !== e.clip) begin
          $error("clamped exp %0d got %0d", e.clip, clamped); errors++;
        end
      end
    end
    if (!rst && in_valid && !in_stall) begin
      if (predict_bin('{mode_t'(mode), chan_first, chan_second, chan_third, weight,
                        read_bin}, r))
        bin_q.push_back(r);
    end
    in_took <= !rst && in_valid && !in_stall;
    out_took <= !rst && out_valid && !out_stall;
  end

  // drive input words with random gaps
  always @(negedge clk) begin
    pixel_word_t w;
    if (!rst && !(in_valid && !in_took)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        w = pixel_q.pop_front();
        mode <= w.op;
        chan_first <= w.c1;
        chan_second <= w.c2;
        chan_third <= w.c3;
        weight <= w.wgt;
        read_bin <= w.rbin;
        in_valid <= 1'b1;
        send_gap = no_idle ? 0 : $urandom_range(0, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // stall the result side at random
  always @(negedge clk) begin
    if (out_took) stall_cnt = no_idle ? 0 : $urandom_range(0, 10);
    if (stall_cnt > 0) begin
      stall_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(cfg_idx_t r, logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= 8'(r);
    cfg_data <= v;
    case (r)
      CFG_BINS_FIRST:  nbins[0] = v[4:0];
      CFG_BINS_SECOND: nbins[1] = v[4:0];
      CFG_BINS_THIRD:  nbins[2] = v[4:0];
      CFG_RANGE_MIN:   lo_val = v;
      CFG_RANGE_MAX:   hi_val = v;
      CFG_CHANNELS:    lanes_on = v[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] b1, b2, b3, mn, mx, ch);
    write_reg(CFG_BINS_FIRST, b1);
    write_reg(CFG_BINS_SECOND, b2);
    write_reg(CFG_BINS_THIRD, b3);
    write_reg(CFG_RANGE_MIN, mn);
    write_reg(CFG_RANGE_MAX, mx);
    write_reg(CFG_CHANNELS, ch);
  endtask

  task automatic push_word(mode_t op, logic [7:0] a, b, c, logic [15:0] w, logic [11:0] rb);
    pixel_q.push_back('{op, a, b, c, w, rb});
  endtask

  // wait for all results and a quiet block, then let a dropped word settle
  task automatic drain();
    while (pixel_q.size() > 0 || in_valid || bin_q.size() > 0 || in_stall)
      @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_chan();
    case ($urandom_range(0, 5))
      0: return lo_val;
      1: return hi_val;
      2: return 8'(lo_val - $urandom_range(0, 3));
      3: return 8'(hi_val + $urandom_range(0, 3));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_words(int n);
    int p;
    logic [15:0] w;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      w = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
      if (p < 70)
        push_word(MODE_ACC, pick_chan(), pick_chan(), pick_chan(), w, 12'($urandom));
      else if (p < 92)
        push_word(MODE_READ, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                  ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 63)) : 12'($urandom));
      else if (p < 94)
        push_word(MODE_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), w, 12'($urandom));
      else
        push_word(MODE_NONE, 8'($urandom), 8'($urandom), 8'($urandom), w, 12'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < HistBins; i++) hist_sums[i] = '0;
    weight_sum = '0;
    nbins[0] = 5'd16; nbins[1] = 5'd16; nbins[2] = 5'd16;
    lo_val = 8'd0; hi_val = 8'd255; lanes_on = 2'd3;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    // let the post-reset store sweep finish
    repeat (4200) @(negedge clk);

    // directed: default registers, field extremes and every mode
    push_word(MODE_ACC, 8'd0, 8'd0, 8'd0, 16'd0, 12'd0);
    push_word(MODE_ACC, 8'd255, 8'd255, 8'd255, 16'hFFFF, 12'hFFF);
    push_word(MODE_ACC, 8'd255, 8'd255, 8'd255, 16'hFFFF, 12'd0);
    push_word(MODE_ACC, 8'd128, 8'd1, 8'd254, 16'h8000, 12'd0);
    push_word(MODE_READ, 8'd0, 8'd0, 8'd0, 16'd0, 12'hFFF);
    push_word(MODE_READ, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 12'd0);
    push_word(MODE_READ, 8'd0, 8'd0, 8'd0, 16'd0, 12'd5);
    push_word(MODE_NONE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 12'hFFF);
    push_word(MODE_CLEAR, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 12'hFFF);
    push_word(MODE_READ, 8'd0, 8'd0, 8'd0, 16'd0, 12'hFFF);
    push_word(MODE_ACC, 8'd10, 8'd20, 8'd30, 16'd1, 12'd0);
    drain();

    // bins clipped both ways, clamped range, one channel
    set_config(8'd0, 8'd31, 8'd1, 8'd50, 8'd200, 8'd0);
    push_word(MODE_ACC, 8'd0, 8'd0, 8'd0, 16'd100, 12'd0);
    push_word(MODE_ACC, 8'd255, 8'd255, 8'd255, 16'd200, 12'd0);
    push_word(MODE_ACC, 8'd125, 8'd0, 8'd0, 16'd300, 12'd0);
    push_word(MODE_READ, 8'd0, 8'd0, 8'd0, 16'd0, 12'd1);
    drain();
    // empty range: min equal to and above max
    set_config(8'd17, 8'd2, 8'd16, 8'd100, 8'd100, 8'd3);
    push_word(MODE_ACC, 8'd100, 8'd7, 8'd200, 16'd5, 12'd0);
    drain();
    set_config(8'd16, 8'd16, 8'd16, 8'd254, 8'd1, 8'd2);
    push_word(MODE_ACC, 8'd3, 8'd4, 8'd5, 16'd9, 12'd0);
    push_word(MODE_READ, 8'd0, 8'd0, 8'd0, 16'd0, 12'd0);
    drain();

    // random phases over varied registers
    for (int ph = 0; ph < 12; ph++) begin
      no_idle = (ph % 4 == 3);
      case (ph)
        0: set_config(8'd16, 8'd16, 8'd16, 8'd0, 8'd255, 8'd3);
        1: set_config(8'd2, 8'd2, 8'd2, 8'd254, 8'd255, 8'd3);
        2: set_config(8'd16, 8'd16, 8'd16, 8'd0, 8'd1, 8'd1);
        default: set_config(8'($urandom_range(0, 31)), 8'($urandom_range(0, 31)),
                            8'($urandom_range(0, 31)), 8'($urandom_range(0, 120)),
                            8'($urandom_range(100, 255)), 8'($urandom_range(0, 3)));
      endcase
      random_words(165);
      drain();
    end

    repeat (200) @(negedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
